/* rtl/pwrseq_pkg.sv */
// shared types and constants for the power sequencer with sleep
package pwrseq_pkg;

    localparam int CFG_W       = 16;
    localparam int BLINK_W     = 9;
    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 32;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 8;
    localparam int RESULT_W    = 6;

    localparam logic [CFG_W-1:0]   RST_ON_DELAY         = 16'd6000;
    localparam logic [CFG_W-1:0]   RST_OFF_DELAY        = 16'd30000;
    localparam logic [CFG_W-1:0]   RST_SLEEP_IDLE_TIME  = 16'd6000;
    localparam logic [CFG_W-1:0]   RST_DEBOUNCE_TIME    = 16'd500;
    localparam logic [CFG_W-1:0]   IDLE_MAX             = 16'hFFFF;
    localparam logic [BLINK_W-1:0] BLINK_HALF           = 9'd150;
    localparam logic [BLINK_W-1:0] BLINK_LAST           = 9'd299;

    typedef enum logic [1:0] {
        REG_ON_DELAY         = 2'd0,
        REG_OFF_DELAY        = 2'd1,
        REG_SLEEP_IDLE_TIME  = 2'd2,
        REG_DEBOUNCE_TIME    = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [CFG_W-1:0] on_delay;
        logic [CFG_W-1:0] off_delay;
        logic [CFG_W-1:0] sleep_idle_time;
        logic [CFG_W-1:0] debounce_time;
    } cfg_t;

    typedef struct packed {
        logic               on_request;
        logic [CFG_W-1:0]   debounce_left;
        logic               relay_level;
        logic               target_level;
        logic               pending_flag;
        logic [CFG_W-1:0]   change_left;
        logic [CFG_W-1:0]   idle_ticks;
        logic               sleeping;
        logic [BLINK_W-1:0] blink_count;
        logic               shutdown_level;
    } seq_state_t;

    localparam seq_state_t STATE_RESET = '{
        on_request:     1'b1,
        debounce_left:  '0,
        relay_level:    1'b0,
        target_level:   1'b0,
        pending_flag:   1'b0,
        change_left:    '0,
        idle_ticks:     '0,
        sleeping:       1'b0,
        blink_count:    '0,
        shutdown_level: 1'b0
    };

    typedef struct packed {
        logic system_up;
        logic button_edge;
        logic alarm_edge;
    } tick_t;

    // packed msb first, so relay_on lands in bit 0
    typedef struct packed {
        logic shutdown_aborted;
        logic change_pending;
        logic sleep_request;
        logic led;
        logic shutdown_request;
        logic relay_on;
    } result_t;

endpackage

/* rtl/pwrseq_core.sv */
// next-state and result logic for one millisecond tick
module pwrseq_core
    import pwrseq_pkg::*;
(
    input  seq_state_t state_cur,
    input  tick_t      tick,
    input  cfg_t       cfg,
    output seq_state_t state_next,
    output result_t    result
);

    logic sleep_pulse;
    logic abort_pulse;
    logic idle_reset;
    logic wanted;

    always_comb begin
        state_next  = state_cur;
        sleep_pulse = 1'b0;
        abort_pulse = 1'b0;
        idle_reset  = 1'b0;
        wanted      = 1'b0;

        if (state_cur.sleeping) begin
            if (tick.alarm_edge) begin
                state_next.on_request = 1'b1;
                state_next.sleeping   = 1'b0;
                state_next.idle_ticks = '0;
            end
        end else begin
            // debounce window
            if (tick.button_edge && state_cur.debounce_left == '0) begin
                state_next.on_request    = ~state_cur.on_request;
                state_next.debounce_left = cfg.debounce_time;
            end else if (state_cur.debounce_left != '0) begin
                state_next.debounce_left = state_cur.debounce_left - 1'b1;
            end

            wanted = tick.system_up | state_next.on_request;

            if (state_cur.pending_flag) begin
                if (state_cur.change_left == '0) begin
                    if (!state_cur.target_level && tick.system_up) begin
                        abort_pulse = 1'b1;
                    end else begin
                        state_next.relay_level = state_cur.target_level;
                        state_next.idle_ticks  = '0;
                        idle_reset             = 1'b1;
                    end
                    state_next.pending_flag = 1'b0;
                end else begin
                    state_next.change_left = state_cur.change_left - 1'b1;
                    state_next.blink_count = (state_cur.blink_count == BLINK_LAST) ?
                        '0 : state_cur.blink_count + 1'b1;
                end
            end else if (state_cur.relay_level != wanted) begin
                if (wanted) begin
                    state_next.change_left    = cfg.on_delay;
                    state_next.shutdown_level = 1'b0;
                end else begin
                    state_next.change_left    = cfg.off_delay;
                    state_next.shutdown_level = 1'b1;
                end
                state_next.target_level = wanted;
                state_next.pending_flag = 1'b1;
                state_next.blink_count  = '0;
            end else begin
                state_next.shutdown_level = 1'b0;
                if (!wanted && state_cur.idle_ticks >= cfg.sleep_idle_time) begin
                    sleep_pulse           = 1'b1;
                    state_next.sleeping   = 1'b1;
                    state_next.idle_ticks = '0;
                    idle_reset            = 1'b1;
                end
            end

            if (!idle_reset && state_cur.idle_ticks != IDLE_MAX) begin
                state_next.idle_ticks = state_cur.idle_ticks + 1'b1;
            end
        end
    end

    always_comb begin
        result.relay_on         = state_next.relay_level;
        result.shutdown_request = state_next.shutdown_level;
        result.led              = state_next.pending_flag ?
                                  (state_next.blink_count >= BLINK_HALF) :
                                  ~state_next.relay_level;
        result.sleep_request    = sleep_pulse;
        result.change_pending   = state_next.pending_flag;
        result.shutdown_aborted = abort_pulse;
    end

endmodule

/* rtl/power_sequencer_with_sleep_core.sv */
// a tick's result is registered into the output register, or the skid entry when full
// one tick per cycle while s_tready is high; a single register pass updates all counters
// a two-entry output stage (register plus skid) keeps s_tready high while one result waits
// reset: synchronous active-low aresetn restores registers to defaults, state to power-on
// values and empties the output stage; no clearing pass
module power_sequencer_with_sleep_core
    import pwrseq_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_W-1:0]    paddr,
    input  logic [DATA_W-1:0]    pwdata,
    output logic [DATA_W-1:0]    prdata,
    output logic                 pready,
    // tick input
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // system_up, button_edge, alarm_edge, zero pad
    // result output
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata   // relay_on, shutdown_request, led,
                                           // sleep_request, change_pending,
                                           // shutdown_aborted, zero pad
);

    cfg_t       cfg_reg;
    seq_state_t state_reg;
    seq_state_t state_next;
    tick_t      tick;
    result_t    result;
    result_t    out_reg;
    result_t    skid_reg;
    logic       out_valid_reg;
    logic       skid_valid_reg;
    logic       cfg_write;
    reg_index_t cfg_index;
    logic       in_fire;
    logic       out_fire;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = reg_index_t'(paddr[ADDR_W-1:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.on_delay         <= RST_ON_DELAY;
            cfg_reg.off_delay        <= RST_OFF_DELAY;
            cfg_reg.sleep_idle_time  <= RST_SLEEP_IDLE_TIME;
            cfg_reg.debounce_time    <= RST_DEBOUNCE_TIME;
        end else if (cfg_write) begin
            unique case (cfg_index)
                REG_ON_DELAY:         cfg_reg.on_delay         <= pwdata[CFG_W-1:0];
                REG_OFF_DELAY:        cfg_reg.off_delay        <= pwdata[CFG_W-1:0];
                REG_SLEEP_IDLE_TIME:  cfg_reg.sleep_idle_time  <= pwdata[CFG_W-1:0];
                REG_DEBOUNCE_TIME:    cfg_reg.debounce_time    <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_index)
            REG_ON_DELAY:         prdata = {{(DATA_W-CFG_W){1'b0}}, cfg_reg.on_delay};
            REG_OFF_DELAY:        prdata = {{(DATA_W-CFG_W){1'b0}}, cfg_reg.off_delay};
            REG_SLEEP_IDLE_TIME:  prdata = {{(DATA_W-CFG_W){1'b0}}, cfg_reg.sleep_idle_time};
            REG_DEBOUNCE_TIME:    prdata = {{(DATA_W-CFG_W){1'b0}}, cfg_reg.debounce_time};
            default:              prdata = '0;
        endcase
    end

    assign tick.system_up   = s_tdata[0];
    assign tick.button_edge = s_tdata[1];
    assign tick.alarm_edge  = s_tdata[2];

    pwrseq_core u_core (
        .state_cur  (state_reg),
        .tick       (tick),
        .cfg        (cfg_reg),
        .state_next (state_next),
        .result     (result)
    );

    assign s_tready = !skid_valid_reg;
    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = out_valid_reg && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= STATE_RESET;
        end else if (in_fire) begin
            state_reg <= state_next;
        end
    end

    // output register with skid entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (in_fire) begin
            if (!out_valid_reg || out_fire) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (out_fire) begin
            if (skid_valid_reg) begin
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            if (!out_valid_reg || out_fire) begin
                out_reg <= result;
            end else begin
                skid_reg <= result;
            end
        end else if (out_fire && skid_valid_reg) begin
            out_reg <= skid_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-RESULT_W){1'b0}}, out_reg};

endmodule
